@@ rtl/qte_pkg.sv @@
package qte_pkg;

  localparam int unsigned QW = 16;
  localparam int unsigned AW = 16;
  localparam int unsigned PW = 15;
  localparam int unsigned SW = 34;
  localparam int unsigned CW = 40;
  localparam int unsigned ZW = 28;
  localparam int unsigned SQW = 58;
  localparam int unsigned SQRT_STEPS = 29;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned ANGLE_ITERATIONS_DEF = 16;

  localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);
  localparam int HALF_PI_Z = 26353589;
  localparam int PI_Q13 = 25736;
  localparam int HALF_PI_Q13 = 12868;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = ZW'(13176795);
      5'd1:  v = ZW'(7778716);
      5'd2:  v = ZW'(4110060);
      5'd3:  v = ZW'(2086331);
      5'd4:  v = ZW'(1047214);
      5'd5:  v = ZW'(524117);
      5'd6:  v = ZW'(262123);
      5'd7:  v = ZW'(131069);
      5'd8:  v = ZW'(65536);
      5'd9:  v = ZW'(32768);
      5'd10: v = ZW'(16384);
      5'd11: v = ZW'(8192);
      5'd12: v = ZW'(4096);
      5'd13: v = ZW'(2048);
      5'd14: v = ZW'(1024);
      5'd15: v = ZW'(512);
      5'd16: v = ZW'(256);
      5'd17: v = ZW'(128);
      5'd18: v = ZW'(64);
      5'd19: v = ZW'(32);
      5'd20: v = ZW'(16);
      5'd21: v = ZW'(8);
      5'd22: v = ZW'(4);
      5'd23: v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/qte_if.sv @@
interface qte_in_if;
  logic valid;
  logic ready;
  logic signed [qte_pkg::QW-1:0] quat_w;
  logic signed [qte_pkg::QW-1:0] quat_x;
  logic signed [qte_pkg::QW-1:0] quat_y;
  logic signed [qte_pkg::QW-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

interface qte_out_if;
  logic valid;
  logic ready;
  logic signed [qte_pkg::AW-1:0] roll_angle;
  logic signed [qte_pkg::PW-1:0] pitch_angle;
  logic signed [qte_pkg::AW-1:0] yaw_angle;
  logic pitch_clamped;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, output pitch_clamped, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle,
                input yaw_angle, input pitch_clamped, output ready);
endinterface

@@ rtl/qte_cordic_lane.sv @@
module qte_cordic_lane #(
  parameter int unsigned ITER = qte_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [qte_pkg::CW-1:0]     vec_x,
  input  logic signed [qte_pkg::CW-1:0]     vec_y,
  output logic signed [qte_pkg::AW-1:0]     angle
);

  localparam int unsigned CW = qte_pkg::CW;
  localparam int unsigned ZW = qte_pkg::ZW;
  localparam int unsigned AW = qte_pkg::AW;
  localparam int unsigned QZ = ZW - 11;
  localparam logic signed [QZ-1:0] PI_LIM = QZ'(qte_pkg::PI_Q13);

  logic signed [CW-1:0] x_r [0:ITER];
  logic signed [CW-1:0] y_r [0:ITER];
  logic signed [ZW-1:0] z_r [0:ITER];
  logic                 zero_r [0:ITER];
  logic signed [AW-1:0] angle_r;

  logic signed [CW-1:0] pre_x_nxt, pre_y_nxt;
  logic signed [ZW-1:0] pre_z_nxt;
  logic signed [ZW-1:0] rnd_sum;
  logic signed [QZ-1:0] rnd_q;
  logic signed [AW-1:0] angle_nxt;

  always_comb begin
    pre_x_nxt = vec_x;
    pre_y_nxt = vec_y;
    pre_z_nxt = '0;
    if (vec_x < 0) begin
      if (vec_y >= 0) begin
        pre_x_nxt = vec_y;
        pre_y_nxt = -vec_x;
        pre_z_nxt = ZW'(qte_pkg::HALF_PI_Z);
      end else begin
        pre_x_nxt = -vec_y;
        pre_y_nxt = vec_x;
        pre_z_nxt = -ZW'(qte_pkg::HALF_PI_Z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= pre_x_nxt;
      y_r[0]    <= pre_y_nxt;
      z_r[0]    <= pre_z_nxt;
      zero_r[0] <= (vec_x == '0) && (vec_y == '0);
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (adv) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + qte_pkg::atan_lut(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - qte_pkg::atan_lut(5'(i));
        end
      end
    end
  end

  always_comb begin
    rnd_sum = z_r[ITER] + ZW'(1024);
    rnd_q = rnd_sum[ZW-1:11];
    if (zero_r[ITER]) begin
      angle_nxt = '0;
    end else if (rnd_q > PI_LIM) begin
      angle_nxt = AW'(PI_LIM);
    end else if (rnd_q < -PI_LIM) begin
      angle_nxt = AW'(-PI_LIM);
    end else begin
      angle_nxt = AW'(rnd_q);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;

endmodule

@@ rtl/quaternion_to_euler_angles_unit.sv @@
// Converts one quaternion (Q2.14) per cycle, while the output is not stalled,
// into roll and yaw in Q3.13 radians and pitch in Q2.13 radians, with a flag
// set when the pitch sine term reaches plus or minus one and pitch saturates
// at plus or minus half pi. The pipeline accepts a request every cycle unless
// the output stalls; each result passes through the registered products and
// sums, the 29-step square root that feeds the pitch arctangent, the CORDIC
// iterations with pre-rotation and rounding, and the output register. A
// stalled output freezes the whole pipeline, so nothing is lost or repeated.
module quaternion_to_euler_angles_unit #(
  parameter int unsigned ANGLE_ITERATIONS = qte_pkg::ANGLE_ITERATIONS_DEF
) (
  input logic   clk,
  input logic   rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  localparam int unsigned QW = qte_pkg::QW;
  localparam int unsigned AW = qte_pkg::AW;
  localparam int unsigned PW = qte_pkg::PW;
  localparam int unsigned SW = qte_pkg::SW;
  localparam int unsigned CW = qte_pkg::CW;
  localparam int unsigned SQW = qte_pkg::SQW;
  localparam int unsigned NSQ = qte_pkg::SQRT_STEPS;
  localparam int unsigned LL = ANGLE_ITERATIONS + 2;
  localparam int unsigned TOT = NSQ + LL + 5;
  localparam int unsigned PRW = 2 * QW;
  localparam logic signed [AW-1:0] HP_LIM = AW'(qte_pkg::HALF_PI_Q13);
  localparam logic [SQW-1:0] ONE_Q56 = SQW'(1) << 56;

  logic adv;
  logic vld_r [0:TOT-1];

  logic signed [QW-1:0] w_r, x_r, y_r, z_r;
  logic signed [PRW-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  logic signed [SW-1:0] ry_r, rx_r, yw_y_r, yw_x_r;
  logic signed [SW-1:0] s_full;
  logic signed [28:0] s29_r;
  logic cpos_r, cneg_r;
  logic [SQW-1:0] sq_r;
  logic signed [SW-1:0] ry3_r, rx3_r, yy3_r, yx3_r;
  logic s3cpos_r, s3cneg_r;
  logic signed [28:0] s3_r;

  logic [SQW-1:0] rem_r [0:NSQ-1];
  logic [SQW-1:0] res_r [0:NSQ-1];
  logic signed [SW-1:0] dry_r [0:NSQ-1];
  logic signed [SW-1:0] drx_r [0:NSQ-1];
  logic signed [SW-1:0] dyy_r [0:NSQ-1];
  logic signed [SW-1:0] dyx_r [0:NSQ-1];
  logic signed [28:0] ds_r [0:NSQ-1];
  logic dcp_r [0:NSQ-1];
  logic dcn_r [0:NSQ-1];

  logic lcp_r [0:LL-1];
  logic lcn_r [0:LL-1];

  logic signed [AW-1:0] roll_a, pitch_a, yaw_a;
  logic signed [AW-1:0] roll_r;
  logic signed [PW-1:0] pitch_r;
  logic signed [AW-1:0] yaw_r;
  logic clamp_r;
  logic signed [AW-1:0] pitch_nxt;

  assign adv = !vld_r[TOT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TOT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < TOT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r <= in_ch.quat_w;
      x_r <= in_ch.quat_x;
      y_r <= in_ch.quat_y;
      z_r <= in_ch.quat_z;
      wx_r <= w_r * x_r;
      yz_r <= y_r * z_r;
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      wz_r <= w_r * z_r;
      xy_r <= x_r * y_r;
      zz_r <= z_r * z_r;
      wy_r <= w_r * y_r;
      zx_r <= z_r * x_r;
    end
  end

  assign s_full = (SW'(wy_r) - SW'(zx_r)) <<< 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      ry_r   <= (SW'(wx_r) + SW'(yz_r)) <<< 1;
      rx_r   <= qte_pkg::ONE_Q28 - ((SW'(xx_r) + SW'(yy_r)) <<< 1);
      yw_y_r <= (SW'(wz_r) + SW'(xy_r)) <<< 1;
      yw_x_r <= qte_pkg::ONE_Q28 - ((SW'(yy_r) + SW'(zz_r)) <<< 1);
      s29_r  <= s_full[28:0];
      cpos_r <= s_full >= qte_pkg::ONE_Q28;
      cneg_r <= s_full <= -qte_pkg::ONE_Q28;

      sq_r     <= SQW'(s29_r * s29_r);
      ry3_r    <= ry_r;
      rx3_r    <= rx_r;
      yy3_r    <= yw_y_r;
      yx3_r    <= yw_x_r;
      s3_r     <= s29_r;
      s3cpos_r <= cpos_r;
      s3cneg_r <= cneg_r;
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NSQ - 1 - j));
    logic [SQW-1:0] rem_in, res_in, trial;
    logic signed [SW-1:0] ry_in, rx_in, yy_in, yx_in;
    logic signed [28:0] s_in;
    logic cp_in, cn_in;
    if (j == 0) begin : g_first
      assign rem_in = ONE_Q56 - sq_r;
      assign res_in = '0;
      assign ry_in  = ry3_r;
      assign rx_in  = rx3_r;
      assign yy_in  = yy3_r;
      assign yx_in  = yx3_r;
      assign s_in   = s3_r;
      assign cp_in  = s3cpos_r;
      assign cn_in  = s3cneg_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign res_in = res_r[j-1];
      assign ry_in  = dry_r[j-1];
      assign rx_in  = drx_r[j-1];
      assign yy_in  = dyy_r[j-1];
      assign yx_in  = dyx_r[j-1];
      assign s_in   = ds_r[j-1];
      assign cp_in  = dcp_r[j-1];
      assign cn_in  = dcn_r[j-1];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          rem_r[j] <= rem_in - trial;
          res_r[j] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[j] <= rem_in;
          res_r[j] <= res_in >> 1;
        end
        dry_r[j] <= ry_in;
        drx_r[j] <= rx_in;
        dyy_r[j] <= yy_in;
        dyx_r[j] <= yx_in;
        ds_r[j]  <= s_in;
        dcp_r[j] <= cp_in;
        dcn_r[j] <= cn_in;
      end
    end
  end

  qte_cordic_lane #(.ITER(ANGLE_ITERATIONS)) u_roll (
    .clk(clk), .adv(adv),
    .vec_x(CW'(drx_r[NSQ-1])), .vec_y(CW'(dry_r[NSQ-1])),
    .angle(roll_a)
  );

  qte_cordic_lane #(.ITER(ANGLE_ITERATIONS)) u_yaw (
    .clk(clk), .adv(adv),
    .vec_x(CW'(dyx_r[NSQ-1])), .vec_y(CW'(dyy_r[NSQ-1])),
    .angle(yaw_a)
  );

  qte_cordic_lane #(.ITER(ANGLE_ITERATIONS)) u_pitch (
    .clk(clk), .adv(adv),
    .vec_x($signed(res_r[NSQ-1][CW-1:0])), .vec_y(CW'(ds_r[NSQ-1])),
    .angle(pitch_a)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      lcp_r[0] <= dcp_r[NSQ-1];
      lcn_r[0] <= dcn_r[NSQ-1];
      for (int k = 1; k < LL; k++) begin
        lcp_r[k] <= lcp_r[k-1];
        lcn_r[k] <= lcn_r[k-1];
      end
    end
  end

  always_comb begin
    priority if (lcp_r[LL-1]) begin
      pitch_nxt = HP_LIM;
    end else if (lcn_r[LL-1]) begin
      pitch_nxt = -HP_LIM;
    end else if (pitch_a > HP_LIM) begin
      pitch_nxt = HP_LIM;
    end else if (pitch_a < -HP_LIM) begin
      pitch_nxt = -HP_LIM;
    end else begin
      pitch_nxt = pitch_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r  <= roll_a;
      yaw_r   <= yaw_a;
      pitch_r <= pitch_nxt[PW-1:0];
      clamp_r <= lcp_r[LL-1] || lcn_r[LL-1];
    end
  end

  assign out_ch.valid         = vld_r[TOT-1];
  assign out_ch.roll_angle    = roll_r;
  assign out_ch.pitch_angle   = pitch_r;
  assign out_ch.yaw_angle     = yaw_r;
  assign out_ch.pitch_clamped = clamp_r;

endmodule

@@ tb/sv/qte_checker.sv @@
module qte_checker #(
  parameter int unsigned ANGLE_ITERATIONS = qte_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  qte_in_if    in_ch,
  qte_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic signed [qte_pkg::AW-1:0] roll;
    logic signed [qte_pkg::PW-1:0] pitch;
    logic signed [qte_pkg::AW-1:0] yaw;
    logic                          clamped;
  } euler_t;

  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint HALF_PI_Z = 26353589;
  localparam longint PI_Q13 = 25736;
  localparam longint HALF_PI_Q13 = 12868;

  localparam longint ARCTAN_STEP [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  euler_t angles_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint zacc;
    longint t;
    longint dx;
    longint dy;
    longint r;
    zacc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        zacc = HALF_PI_Z;
      end else begin
        xv = -yv;
        yv = t;
        zacc = -HALF_PI_Z;
      end
    end
    for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv = xv + dx;
        yv = yv - dy;
        zacc = zacc + ARCTAN_STEP[i];
      end else begin
        xv = xv - dx;
        yv = yv + dy;
        zacc = zacc - ARCTAN_STEP[i];
      end
    end
    r = (zacc + 1024) >>> 11;
    if (r > PI_Q13) r = PI_Q13;
    if (r < -PI_Q13) r = -PI_Q13;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(longint w, longint x, longint y, longint z);
    euler_t e;
    longint roll;
    longint pitch;
    longint yaw;
    longint s;
    longint unsigned c;
    e.clamped = 1'b0;
    roll = vector_angle(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y));
    yaw = vector_angle(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z));
    s = 2 * (w * y - z * x);
    if (s >= ONE_Q28) begin
      pitch = HALF_PI_Q13;
      e.clamped = 1'b1;
    end else if (s <= -ONE_Q28) begin
      pitch = -HALF_PI_Q13;
      e.clamped = 1'b1;
    end else begin
      c = int_sqrt((64'd1 << 56) - longint'(s * s));
      pitch = vector_angle(s, longint'(c));
      if (pitch > HALF_PI_Q13) pitch = HALF_PI_Q13;
      if (pitch < -HALF_PI_Q13) pitch = -HALF_PI_Q13;
    end
    e.roll = roll[qte_pkg::AW-1:0];
    e.pitch = pitch[qte_pkg::PW-1:0];
    e.yaw = yaw[qte_pkg::AW-1:0];
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    euler_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        angles_q.push_back(quat_to_euler(in_ch.quat_w, in_ch.quat_x,
                                         in_ch.quat_y, in_ch.quat_z));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (angles_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = angles_q.pop_front();
          if (out_ch.roll_angle !== want.roll)
            report_mismatch("roll", out_ch.roll_angle, want.roll);
          if (out_ch.pitch_angle !== want.pitch)
            report_mismatch("pitch", out_ch.pitch_angle, want.pitch);
          if (out_ch.yaw_angle !== want.yaw)
            report_mismatch("yaw", out_ch.yaw_angle, want.yaw);
          if (out_ch.pitch_clamped !== want.clamped)
            report_mismatch("clamp", out_ch.pitch_clamped, want.clamped);
        end
      end
      pending = angles_q.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int LATENCY = qte_pkg::ANGLE_ITERATIONS_DEF + 36;
  localparam int N_RANDOM = 430;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   quiet;
  bit   long_hold;

  qte_in_if  in_ch ();
  qte_out_if out_ch ();

  quaternion_to_euler_angles_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  qte_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 200000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_request(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                              logic [15:0] z);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.quat_w = w;
    in_ch.quat_x = x;
    in_ch.quat_y = y;
    in_ch.quat_z = z;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp(bit raw);
    if (raw) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready = 1'b0;
        repeat (150) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    bit raw;
    quiet = 1'b0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_request(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_request(16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
    send_request(16'sd16384, 16'sd0, -16'sd16384, 16'sd0);
    send_request(16'sd0, 16'sd16384, 16'sd0, -16'sd16384);
    send_request(16'sd0, 16'sd8192, 16'sd8192, 16'sd0);
    send_request(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    send_request(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_request(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
    send_request(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
    send_request(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
    send_request(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_request(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    send_request(16'hffff, 16'hffff, 16'hffff, 16'hffff);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 120) long_hold = 1'b1;
      if (i == 250) begin
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (i == 360) quiet = 1'b1;
      raw = ($urandom_range(0, 4) == 0);
      send_request(rand_comp(raw), rand_comp(raw), rand_comp(raw), rand_comp(raw));
    end
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
